@@ hdl/assert_macros.svh @@
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// implication checked in the following cycle
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

@@ hdl/tli_pkg.sv @@
// ----------------------------------------------------------------------------
// tli_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
`default_nettype none
package tli_pkg;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int CORDIC_STEPS = 16;
   localparam logic [1:0] REG_TURN_STEP = 2'd0;
   localparam logic [1:0] REG_STEP_LENGTH = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;
   localparam logic [1:0] KIND_UNDERFLOW = 2'd3;
   localparam logic [7:0] SYM_DRAW = 8'h46;
   localparam logic [7:0] SYM_MOVE = 8'h66;
   localparam logic [7:0] SYM_PLUS = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_PUSH = 8'h5B;
   localparam logic [7:0] SYM_POP = 8'h5D;
   localparam logic [15:0] CORDIC_GAIN = 16'd39797;
   localparam logic [22:0] STEP_LENGTH_RESET = 23'd655360;

   typedef struct packed {
      logic [7:0] symbol;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic restart;   // clear turtle
      logic load;      // start move setup
      logic iterate;   // one cordic step
      logic commit;    // add displacement
      logic turn_add;
      logic turn_sub;
      logic push;
      logic pop_read;  // read stack entry
      logic pop_load;  // restore from read data
      logic [1:0] kind;
      logic draw;
      logic respond;   // load result register without a move
   } cmd_type;

   typedef struct packed {
      logic stack_full;
      logic stack_empty;
   } sts_type;

   function automatic logic [31:0] atan_entry(input logic [3:0] i);
      logic [31:0] v;
      case (i)
         4'd0: v = 32'h20000000;  4'd1: v = 32'h12E4051D;
         4'd2: v = 32'h09FB385B;  4'd3: v = 32'h051111D4;
         4'd4: v = 32'h028B0D43;  4'd5: v = 32'h0145D7E1;
         4'd6: v = 32'h00A2F61E;  4'd7: v = 32'h00517C55;
         4'd8: v = 32'h0028BE53;  4'd9: v = 32'h00145F2E;
         4'd10: v = 32'h000A2F98; 4'd11: v = 32'h000517CC;
         4'd12: v = 32'h00028BE6; 4'd13: v = 32'h000145F3;
         4'd14: v = 32'h0000A2F9; 4'd15: v = 32'h0000517C;
         default: v = 32'h0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

@@ hdl/turtle_line_interpreter.sv @@
// Turtle interpreter for L-system symbols: one request (symbol plus restart flag) gives
// exactly one response. For 'F' and 'f' the move runs through a decode/setup state, the
// 16 steps of the shared CORDIC rotator and a result state; ']' on a non-empty stack adds
// a state for the registered stack read; all other symbols go from decode to the result
// state. One request is in flight at a time and the next is accepted from the cycle the
// response goes valid, unless rsp_stall holds that response. The save stack is a memory
// of STACK_DEPTH entries needing no clearing pass.
`default_nettype none
module turtle_line_interpreter #(
   parameter int STACK_DEPTH = tli_pkg::STACK_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tli_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tli_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [1:0]       csr_index,
   input  wire logic [22:0]      csr_data
);
   tli_pkg::cmd_type cmd;
   tli_pkg::sts_type sts;
   logic [15:0] turn_step_ff;
   logic [22:0] step_length_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         turn_step_ff <= '0;
         step_length_ff <= tli_pkg::STEP_LENGTH_RESET;
      end else if (csr_write) begin
         if (csr_index == tli_pkg::REG_TURN_STEP) turn_step_ff <= csr_data[15:0];
         if (csr_index == tli_pkg::REG_STEP_LENGTH) step_length_ff <= csr_data;
      end
   end

   tli_control u_control (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .sts, .cmd
   );

   tli_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
      .clock, .reset, .cmd, .turn_step(turn_step_ff),
      .step_length(step_length_ff), .sts, .result(rsp_data)
   );
endmodule
`default_nettype wire

@@ hdl/tli_datapath.sv @@
// ----------------------------------------------------------------------------
// tli_datapath
// turtle state, save stack memory and shared cordic rotator
// ----------------------------------------------------------------------------
`default_nettype none
module tli_datapath #(
   parameter int STACK_DEPTH = tli_pkg::STACK_DEPTH_DEF,
   localparam int LW = $clog2(STACK_DEPTH + 1),
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire tli_pkg::cmd_type cmd,
   input  wire logic [15:0]     turn_step,
   input  wire logic [22:0]     step_length,
   output tli_pkg::sts_type     sts,
   output tli_pkg::rsp_type     result
);
   logic [31:0] pos_x_ff, pos_y_ff;
   logic [15:0] heading_ff;
   logic [LW-1:0] level_ff;
   logic [79:0] stack_mem [STACK_DEPTH];
   logic [79:0] rd_data_ff;
   // cordic registers, 2^-16 units scaled length fits 36 bits signed
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [33:0] cz_ff;
   logic [3:0] iter_ff;
   logic [1:0] quad_ff;
   logic [38:0] scaled;
   logic signed [35:0] xs, ys, dxv, dyv;

   assign scaled = 39'(step_length) * 39'(tli_pkg::CORDIC_GAIN) + 39'd32768;
   assign xs = cx_ff >>> iter_ff;
   assign ys = cy_ff >>> iter_ff;
   assign sts.stack_full = (level_ff == LW'(STACK_DEPTH));
   assign sts.stack_empty = (level_ff == '0);

   // quadrant mapping to displacement
   always_comb begin
      case (quad_ff)
         2'd0: begin dxv = cy_ff;  dyv = cx_ff;  end
         2'd1: begin dxv = cx_ff;  dyv = -cy_ff; end
         2'd2: begin dxv = -cy_ff; dyv = -cx_ff; end
         default: begin dxv = -cx_ff; dyv = cy_ff; end
      endcase
   end

   // cordic rotator
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff <= 36'(scaled[38:16]);
         cy_ff <= '0;
         cz_ff <= 34'({heading_ff[13:0], 16'h0});
         quad_ff <= heading_ff[15:14];
         iter_ff <= '0;
      end else if (cmd.iterate) begin
         if (!cz_ff[33]) begin
            cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - 34'(tli_pkg::atan_entry(iter_ff));
         end else begin
            cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + 34'(tli_pkg::atan_entry(iter_ff));
         end
         iter_ff <= iter_ff + 4'd1;
      end
   end

   // save stack memory
   always_ff @(posedge clock) begin
      if (cmd.push && !sts.stack_full)
         stack_mem[AW'(level_ff)] <= {pos_x_ff, pos_y_ff, heading_ff};
      if (cmd.pop_read)
         rd_data_ff <= stack_mem[AW'(level_ff - LW'(1))];
   end

   // turtle state
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         pos_x_ff <= '0; pos_y_ff <= '0; heading_ff <= '0; level_ff <= '0;
      end else if (cmd.commit) begin
         pos_x_ff <= pos_x_ff + dxv[31:0];
         pos_y_ff <= pos_y_ff + dyv[31:0];
      end else if (cmd.turn_add) begin
         heading_ff <= heading_ff + turn_step;
      end else if (cmd.turn_sub) begin
         heading_ff <= heading_ff - turn_step;
      end else if (cmd.push && !sts.stack_full) begin
         level_ff <= level_ff + LW'(1);
      end else if (cmd.pop_load) begin
         level_ff <= level_ff - LW'(1);
         {pos_x_ff, pos_y_ff, heading_ff} <= rd_data_ff;
      end
   end

   // result register, loaded once per request
   always_ff @(posedge clock) begin
      if (cmd.commit || cmd.respond) begin
         result.kind <= cmd.kind;
         result.start_x <= '0; result.start_y <= '0;
         result.end_x <= '0; result.end_y <= '0;
         if (cmd.draw) begin
            result.start_x <= pos_x_ff;
            result.start_y <= pos_y_ff;
            result.end_x <= pos_x_ff + dxv[31:0];
            result.end_y <= pos_y_ff + dyv[31:0];
         end
      end
   end
endmodule
`default_nettype wire

@@ hdl/tli_control.sv @@
// ----------------------------------------------------------------------------
// tli_control
// sequencer for one symbol and the output handshake
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tli_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tli_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire tli_pkg::sts_type sts,
   output tli_pkg::cmd_type      cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_ROTATE = 3'd2;
   localparam logic [2:0] ST_POP = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [7:0] sym_ff;
   logic [3:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.restart = req_data.restart;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            case (sym_ff)
               tli_pkg::SYM_DRAW, tli_pkg::SYM_MOVE: begin
                  cmd.load = 1'b1; cnt_in = '0; state_in = ST_ROTATE;
               end
               tli_pkg::SYM_PLUS: cmd.turn_sub = 1'b1;
               tli_pkg::SYM_MINUS: cmd.turn_add = 1'b1;
               tli_pkg::SYM_PUSH: begin
                  cmd.push = 1'b1;
                  if (sts.stack_full) cmd.kind = tli_pkg::KIND_OVERFLOW;
               end
               tli_pkg::SYM_POP: begin
                  if (sts.stack_empty) cmd.kind = tli_pkg::KIND_UNDERFLOW;
                  else begin cmd.pop_read = 1'b1; state_in = ST_POP; end
               end
               default: ;
            endcase
            // symbols without a move or a stack read finish their result here
            if (state_in == ST_DONE) cmd.respond = 1'b1;
         end
         ST_ROTATE: begin
            if (cnt_ff == 4'(tli_pkg::CORDIC_STEPS - 1)) begin
               state_in = ST_DONE;
               cmd.iterate = 1'b1;
               cnt_in = cnt_ff;
            end else begin
               cmd.iterate = 1'b1;
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_POP: begin
            cmd.pop_load = 1'b1;
            cmd.respond = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (sym_ff == tli_pkg::SYM_DRAW) cmd.draw = 1'b1;
               if (sym_ff == tli_pkg::SYM_DRAW || sym_ff == tli_pkg::SYM_MOVE)
                  cmd.commit = 1'b1;
               if (sym_ff == tli_pkg::SYM_DRAW) cmd.kind = tli_pkg::KIND_LINE;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) sym_ff <= req_data.symbol;
   end

   `ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !accept)
   `ASSERT_NEXT(a_accept_decode, clock, reset, accept, state_ff == ST_DECODE)
   `ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.load, cmd.iterate, cmd.turn_add, cmd.turn_sub, cmd.pop_load}))
endmodule
`default_nettype wire
